// ===== rtl/svg_pkg.sv =====
// Shared types, constants and codes for the serial-attribute video generator.
package svg_pkg;

   // Screen geometry.
   localparam int CELLS_PER_LINE = 40;
   localparam int GRAPHIC_LINES  = 200;

   // Default depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Memory map of the screen and the character sets.
   localparam logic [15:0] HIRES_SCREEN_BASE  = 16'hA000;
   localparam logic [15:0] TEXT_SCREEN_BASE   = 16'hBB80;
   localparam logic [15:0] HIRES_CHARSET_BASE = 16'h9800;
   localparam logic [15:0] TEXT_CHARSET_BASE  = 16'hB400;
   localparam logic [15:0] FORCED_TEXT_BASE   = 16'hBF68;
   localparam logic [15:0] ALT_CHARSET_OFFSET = 16'(128 * 8);

   // Reset and line start values.
   localparam logic [5:0] FLASH_PERIOD_RESET = 6'd30;
   localparam logic [2:0] LINE_START_FORE    = 3'd7;

   // Transaction opcodes.
   typedef enum logic [1:0] {
      OP_FRAME_TICK   = 2'd0,
      OP_LINE_START   = 2'd1,
      OP_SCREEN_BYTE  = 2'd2,
      OP_PATTERN_BYTE = 2'd3
   } opcode_type;

   // Which register a serial attribute writes.
   typedef enum logic [1:0] {
      ATTR_FORE  = 2'd0,
      ATTR_TEXT  = 2'd1,
      ATTR_BACK  = 2'd2,
      ATTR_MODE  = 2'd3
   } attr_group_type;

   // Input transaction.
   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  line_number;
      logic [7:0]  data;
   } req_payload_type;

   // Result transaction.
   typedef struct packed {
      logic        pixels_valid;
      logic [5:0]  pixel_bits;
      logic [2:0]  fore_colour;
      logic [2:0]  back_colour;
      logic [5:0]  cell_index;
      logic        fetch_valid;
      logic        fetch_is_pattern;
      logic [15:0] fetch_address;
      logic        line_end;
   } rsp_payload_type;

   // Classified transaction held in the queue.
   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  line_number;
      logic [7:0]  data;
      logic        is_attribute;
      logic        invert;
   } entry_type;

endpackage

// ===== rtl/svg_front.sv =====
// Front end: accepts input transactions and classifies them for the queue.
module svg_front
   import svg_pkg::*;
(
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            queue_full,
   output logic            push,
   output entry_type       push_entry
);

   // Accept whenever the queue has room.
   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   // A screen byte with bits 6 and 5 clear is a serial attribute; bit 7 inverts the cell.
   always_comb begin
      push_entry.opcode       = req_payload.opcode;
      push_entry.line_number  = req_payload.line_number;
      push_entry.data         = req_payload.data;
      push_entry.is_attribute = (req_payload.data[6:5] == 2'b00);
      push_entry.invert       = req_payload.data[7];
   end

endmodule

// ===== rtl/svg_queue.sv =====
// Short first-in first-out queue between the front and the back.
module svg_queue
   import svg_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type head,
   output logic      empty
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type              entries_ff [DEPTH];
   logic      [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic      [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic      [CNT_W-1:0]  count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/svg_back.sv =====
// Back end: keeps the video state, executes queued transactions and registers the results.
module svg_back
   import svg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [5:0]      csr_write_data,
   input  entry_type       head,
   input  logic            empty,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   // Video state.
   logic [5:0]  flash_period_ff;
   logic [7:0]  current_line_ff,   current_line_in;
   logic [5:0]  current_cell_ff,   current_cell_in;
   logic [2:0]  fore_ff,           fore_in;
   logic [2:0]  back_ff,           back_in;
   logic [2:0]  text_attr_ff,      text_attr_in;
   logic [2:0]  video_mode_ff,     video_mode_in;
   logic [15:0] screen_base_ff,    screen_base_in;
   logic        hires_ff,          hires_in;
   logic [5:0]  flash_counter_ff,  flash_counter_in;
   logic        flash_phase_ff,    flash_phase_in;
   logic        pending_invert_ff, pending_invert_in;
   logic        awaiting_ff,       awaiting_in;

   // Result register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type result;
   logic            produce;

   // Screen byte address of a cell on a line.
   function automatic logic [15:0] screen_address(input logic [7:0]  line,
                                                  input logic [5:0]  cell_pos,
                                                  input logic [15:0] base,
                                                  input logic        hires);
      logic [7:0]  row;
      logic [7:0]  below;
      logic [12:0] row_offset;
      below = line - 8'(GRAPHIC_LINES);
      if (line < 8'(GRAPHIC_LINES)) begin
         row = hires ? line : {3'b000, line[7:3]};
      end else begin
         row = {3'b000, below[7:3]};
      end
      row_offset = 13'(row) * 13'(CELLS_PER_LINE);
      return base + {10'b0, cell_pos} + {3'b000, row_offset};
   endfunction

   // A queued transaction is executed once the result register is free or being emptied.
   assign pop         = !empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Execution of the transaction at the head of the queue.
   always_comb begin
      logic        deliver;
      logic [5:0]  bits;
      logic        inv;
      logic [5:0]  counter_sum;
      logic [2:0]  fg;
      logic [2:0]  bg;
      logic [2:0]  chl;
      logic [15:0] charset;
      logic [5:0]  next_cell;

      current_line_in   = current_line_ff;
      current_cell_in   = current_cell_ff;
      fore_in           = fore_ff;
      back_in           = back_ff;
      text_attr_in      = text_attr_ff;
      video_mode_in     = video_mode_ff;
      screen_base_in    = screen_base_ff;
      hires_in          = hires_ff;
      flash_counter_in  = flash_counter_ff;
      flash_phase_in    = flash_phase_ff;
      pending_invert_in = pending_invert_ff;
      awaiting_in       = awaiting_ff;
      result            = '0;
      produce           = 1'b0;
      deliver           = 1'b0;
      bits              = '0;
      inv               = 1'b0;
      counter_sum       = flash_counter_ff + 1'b1;
      fg                = '0;
      bg                = '0;
      next_cell         = current_cell_ff + 1'b1;

      // Pattern row within the character, halved and offset for double height.
      chl = current_line_ff[2:0];
      if (text_attr_ff[1]) begin
         chl = {current_line_ff[3], current_line_ff[2:1]};
      end
      charset = video_mode_ff[2] ? HIRES_CHARSET_BASE : TEXT_CHARSET_BASE;
      if (text_attr_ff[0]) begin
         charset = charset + ALT_CHARSET_OFFSET;
      end

      unique case (head.opcode)
         OP_FRAME_TICK: begin
            if (counter_sum == flash_period_ff) begin
               flash_counter_in = '0;
               flash_phase_in   = !flash_phase_ff;
            end else begin
               flash_counter_in = counter_sum;
            end
         end
         OP_LINE_START: begin
            current_line_in   = head.line_number;
            current_cell_in   = '0;
            fore_in           = LINE_START_FORE;
            back_in           = '0;
            text_attr_in      = '0;
            pending_invert_in = 1'b0;
            awaiting_in       = 1'b0;
            if (head.line_number == '0) begin
               screen_base_in = video_mode_ff[2] ? HIRES_SCREEN_BASE : TEXT_SCREEN_BASE;
               hires_in       = video_mode_ff[2];
            end
            if (head.line_number >= 8'(GRAPHIC_LINES)) begin
               screen_base_in = FORCED_TEXT_BASE;
               hires_in       = 1'b0;
            end
            produce              = 1'b1;
            result.fetch_valid   = 1'b1;
            result.fetch_address = screen_address(head.line_number, '0,
                                                  screen_base_in, hires_in);
         end
         OP_SCREEN_BYTE: begin
            if (current_cell_ff < 6'(CELLS_PER_LINE)) begin
               produce     = 1'b1;
               awaiting_in = 1'b0;
               if (head.is_attribute) begin
                  // Serial attribute: update one register, show background only.
                  unique case (attr_group_type'(head.data[4:3]))
                     ATTR_FORE: fore_in       = head.data[2:0];
                     ATTR_TEXT: text_attr_in  = head.data[2:0];
                     ATTR_BACK: back_in       = head.data[2:0];
                     ATTR_MODE: video_mode_in = head.data[2:0];
                     default:   fore_in       = fore_ff;
                  endcase
                  if (current_line_ff < 8'(GRAPHIC_LINES)) begin
                     screen_base_in = video_mode_in[2] ? HIRES_SCREEN_BASE
                                                       : TEXT_SCREEN_BASE;
                     hires_in       = video_mode_in[2];
                  end
                  deliver = 1'b1;
                  inv     = head.invert;
               end else if (hires_ff) begin
                  deliver = 1'b1;
                  bits    = head.data[5:0];
                  inv     = head.invert;
               end else begin
                  // Text character: ask for its pattern byte.
                  pending_invert_in       = head.invert;
                  awaiting_in             = 1'b1;
                  result.fetch_valid      = 1'b1;
                  result.fetch_is_pattern = 1'b1;
                  result.fetch_address    = charset + {6'b0, head.data[6:0], 3'b000}
                                            + {13'b0, chl};
               end
            end
         end
         OP_PATTERN_BYTE: begin
            if ((current_cell_ff < 6'(CELLS_PER_LINE)) && awaiting_ff) begin
               produce     = 1'b1;
               awaiting_in = 1'b0;
               deliver     = 1'b1;
               bits        = head.data[5:0];
               inv         = pending_invert_ff;
            end
         end
         default: begin
            produce = 1'b0;
         end
      endcase

      // Cell delivery: colours after flash and inversion, then advance the cell.
      if (deliver) begin
         fg = fore_in;
         bg = back_in;
         if (text_attr_in[2] && flash_phase_ff) begin
            fg = bg;
         end
         if (inv) begin
            fg = ~fg;
            bg = ~bg;
         end
         result.pixels_valid = 1'b1;
         result.pixel_bits   = bits;
         result.fore_colour  = fg;
         result.back_colour  = bg;
         result.cell_index   = current_cell_ff;
         current_cell_in     = next_cell;
         if (next_cell >= 6'(CELLS_PER_LINE)) begin
            current_cell_in = 6'(CELLS_PER_LINE);
            result.line_end = 1'b1;
         end else begin
            result.fetch_valid   = 1'b1;
            result.fetch_address = screen_address(current_line_ff, next_cell,
                                                  screen_base_in, hires_in);
         end
      end
   end

   // Result register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop && produce) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         flash_period_ff   <= FLASH_PERIOD_RESET;
         current_line_ff   <= '0;
         current_cell_ff   <= '0;
         fore_ff           <= '0;
         back_ff           <= '0;
         text_attr_ff      <= '0;
         video_mode_ff     <= '0;
         screen_base_ff    <= TEXT_SCREEN_BASE;
         hires_ff          <= 1'b0;
         flash_counter_ff  <= '0;
         flash_phase_ff    <= 1'b0;
         pending_invert_ff <= 1'b0;
         awaiting_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            flash_period_ff <= csr_write_data;
         end
         if (pop) begin
            current_line_ff   <= current_line_in;
            current_cell_ff   <= current_cell_in;
            fore_ff           <= fore_in;
            back_ff           <= back_in;
            text_attr_ff      <= text_attr_in;
            video_mode_ff     <= video_mode_in;
            screen_base_ff    <= screen_base_in;
            hires_ff          <= hires_in;
            flash_counter_ff  <= flash_counter_in;
            flash_phase_ff    <= flash_phase_in;
            pending_invert_ff <= pending_invert_in;
            awaiting_ff       <= awaiting_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      if (pop && produce) begin
         rsp_payload_ff <= result;
      end
   end

endmodule

// ===== rtl/serial_attribute_video_generator.sv =====
// Serial-attribute video generator for a 40-cell by 224-line screen. Frame ticks, line
// starts, screen bytes and pattern bytes enter as transactions on the req_ channel; the
// block answers with at most one result transaction each, carrying a six-pixel cell with
// its colours and/or the address of the next memory fetch. One transaction is accepted
// every clock cycle while the queue has room; the back end sets the sustained rate and
// executes one queued transaction per cycle while the output register is free or being
// emptied, against its state registers, and places the result in an output register,
// so a transaction is queued and then its result registered. The flash period is
// written through csr_ by the user only while idle; the block does not enforce this.
module serial_attribute_video_generator
   import svg_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_write_enable,
   input  logic [5:0]      csr_write_data
);

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   entry_type head;
   logic      queue_empty;

   // Acceptance and classification.
   svg_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Decoupling queue.
   svg_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty)
   );

   // Execution and result register.
   svg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .head            (head),
      .empty           (queue_empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload)
   );

endmodule

// ===== verif/tb_serial_attribute_video_generator.sv =====
// Self-checking testbench for the serial-attribute video generator.
`timescale 1ns / 100ps

module tb_serial_attribute_video_generator
   import svg_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int REPORT_LIMIT   = 10;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable = 1'b0;
   logic [5:0]      csr_write_data = '0;

   // Shadow of the block's raster, colour and flash state.
   logic [5:0]  flash_period_reg;
   logic [7:0]  ras_line;
   logic [5:0]  ras_cell;
   logic [2:0]  ras_fore;
   logic [2:0]  ras_back;
   logic [2:0]  ras_text_attr;
   logic [2:0]  ras_mode;
   logic [15:0] ras_base;
   logic        ras_hires;
   logic [5:0]  flash_ticks;
   logic        flash_phase;
   logic        pend_invert;
   logic        pat_awaited;

   rsp_payload_type expected_video_out[$];
   int effective_items = 0;
   int fault_count     = 0;
   int quiet_cycles    = 0;
   int stall_left      = 0;
   bit idle_on         = 1'b1;

   serial_attribute_video_generator u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap length: mostly none, sometimes short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 70)
         return 0;
      else if (roll < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] attr_byte(input attr_group_type group, input logic [2:0] v,
                                            input logic inv);
      return {inv, 2'b00, group, v};
   endfunction

   // Address of the screen byte for the current cell.
   function automatic logic [15:0] screen_addr();
      int row;
      if (ras_line < GRAPHIC_LINES)
         row = ras_hires ? int'(ras_line) : int'(ras_line >> 3);
      else
         row = (int'(ras_line) - GRAPHIC_LINES) >> 3;
      return 16'(int'(ras_base) + int'(ras_cell) + row * CELLS_PER_LINE);
   endfunction

   // The screen base and hires flag follow the video mode.
   task automatic follow_mode();
      ras_base  = ras_mode[2] ? HIRES_SCREEN_BASE : TEXT_SCREEN_BASE;
      ras_hires = ras_mode[2];
   endtask

   // Deliver the current cell, advance, and fetch the next screen byte.
   task automatic emit_cell(inout rsp_payload_type o, input logic [5:0] bits,
                            input logic inv);
      logic [2:0] fg;
      logic [2:0] bg;
      fg = ras_fore;
      bg = ras_back;
      if (ras_text_attr[2] && flash_phase)
         fg = bg;
      if (inv) begin
         fg = ~fg;
         bg = ~bg;
      end
      o.pixels_valid = 1'b1;
      o.pixel_bits   = bits;
      o.fore_colour  = fg;
      o.back_colour  = bg;
      o.cell_index   = ras_cell;
      ras_cell = ras_cell + 6'd1;
      if (ras_cell >= CELLS_PER_LINE) begin
         ras_cell   = 6'(CELLS_PER_LINE);
         o.line_end = 1'b1;
      end else begin
         o.fetch_valid   = 1'b1;
         o.fetch_address = screen_addr();
      end
   endtask

   // Advance the shadow state by one accepted transaction and queue its result.
   task automatic video_step(input req_payload_type item);
      rsp_payload_type o;
      logic            has_out;
      logic [7:0]      c;
      logic [2:0]      chrow;
      logic [15:0]     cbase;
      o       = '0;
      has_out = 1'b0;
      c       = item.data;
      case (item.opcode)
         OP_FRAME_TICK: begin
            flash_ticks = flash_ticks + 6'd1;
            if (flash_ticks == flash_period_reg) begin
               flash_ticks = '0;
               flash_phase = ~flash_phase;
            end
            effective_items++;
         end
         OP_LINE_START: begin
            ras_line      = item.line_number;
            ras_cell      = '0;
            ras_fore      = LINE_START_FORE;
            ras_back      = '0;
            ras_text_attr = '0;
            pend_invert   = 1'b0;
            pat_awaited   = 1'b0;
            if (ras_line == 8'd0)
               follow_mode();
            if (ras_line >= GRAPHIC_LINES) begin
               ras_base  = FORCED_TEXT_BASE;
               ras_hires = 1'b0;
            end
            o.fetch_valid   = 1'b1;
            o.fetch_address = screen_addr();
            has_out = 1'b1;
         end
         OP_SCREEN_BYTE: begin
            if (ras_cell < CELLS_PER_LINE) begin
               pat_awaited = 1'b0;
               has_out     = 1'b1;
               if (c[6:5] == 2'b00) begin
                  // Serial attribute: update one register, show background.
                  case (attr_group_type'(c[4:3]))
                     ATTR_FORE: ras_fore      = c[2:0];
                     ATTR_TEXT: ras_text_attr = c[2:0];
                     ATTR_BACK: ras_back      = c[2:0];
                     ATTR_MODE: ras_mode      = c[2:0];
                  endcase
                  if (ras_line < GRAPHIC_LINES)
                     follow_mode();
                  emit_cell(o, 6'd0, c[7]);
               end else if (ras_hires) begin
                  emit_cell(o, c[5:0], c[7]);
               end else begin
                  // Text: ask for the pattern byte of this character row.
                  cbase = ras_mode[2] ? HIRES_CHARSET_BASE : TEXT_CHARSET_BASE;
                  if (ras_text_attr[0])
                     cbase = cbase + ALT_CHARSET_OFFSET;
                  chrow = ras_line[2:0];
                  if (ras_text_attr[1])
                     chrow = {ras_line[3], ras_line[2:1]};
                  pend_invert        = c[7];
                  pat_awaited        = 1'b1;
                  o.fetch_valid      = 1'b1;
                  o.fetch_is_pattern = 1'b1;
                  o.fetch_address    = cbase + {6'd0, c[6:0], 3'b000} + {13'd0, chrow};
               end
               effective_items++;
            end
         end
         OP_PATTERN_BYTE: begin
            if (ras_cell < CELLS_PER_LINE && pat_awaited) begin
               pat_awaited = 1'b0;
               emit_cell(o, c[5:0], pend_invert);
               has_out = 1'b1;
               effective_items++;
            end
         end
      endcase
      if (has_out)
         expected_video_out.push_back(o);
   endtask

   // Send one transaction, with a random gap before it.
   task automatic send_item(input opcode_type op, input logic [7:0] line,
                            input logic [7:0] value);
      req_payload_type item;
      int              gap;
      item.opcode      = op;
      item.line_number = line;
      item.data        = value;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      video_step(item);
   endtask

   // Let every expected result arrive, then allow queued ticks to drain.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_video_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_flash_period(input logic [5:0] period);
      csr_write_data   <= period;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      flash_period_reg = period;
   endtask

   // Attribute groups, inversion, hires, text, charsets and line edge cases.
   task automatic test_directed_cells();
      send_item(OP_PATTERN_BYTE, 8'hFF, 8'hFF);
      send_item(OP_LINE_START, 8'd0, 8'h00);
      send_item(OP_SCREEN_BYTE, 8'h00, attr_byte(ATTR_FORE, 3'd0, 1'b0));
      send_item(OP_SCREEN_BYTE, 8'h00, attr_byte(ATTR_TEXT, 3'd5, 1'b0));
      send_item(OP_SCREEN_BYTE, 8'h00, attr_byte(ATTR_BACK, 3'd4, 1'b1));
      send_item(OP_SCREEN_BYTE, 8'h00, 8'h41);
      // A screen byte arriving while a pattern byte is awaited.
      send_item(OP_SCREEN_BYTE, 8'h00, 8'hE2);
      send_item(OP_PATTERN_BYTE, 8'h00, 8'hFF);
      send_item(OP_SCREEN_BYTE, 8'h00, attr_byte(ATTR_MODE, 3'd6, 1'b0));
      send_item(OP_SCREEN_BYTE, 8'h00, 8'h7F);
      send_item(OP_PATTERN_BYTE, 8'h00, 8'h55);
      send_item(OP_SCREEN_BYTE, 8'hFF, 8'hA0);
      // Last graphic line, then back to text with double height.
      send_item(OP_LINE_START, 8'd199, 8'hFF);
      send_item(OP_SCREEN_BYTE, 8'h00, attr_byte(ATTR_MODE, 3'd0, 1'b0));
      send_item(OP_SCREEN_BYTE, 8'h00, attr_byte(ATTR_TEXT, 3'd2, 1'b0));
      send_item(OP_SCREEN_BYTE, 8'h00, 8'h5A);
      send_item(OP_PATTERN_BYTE, 8'h00, 8'h2A);
      send_item(OP_LINE_START, 8'd200, 8'h00);
      send_item(OP_SCREEN_BYTE, 8'h00, 8'h7F);
      send_item(OP_PATTERN_BYTE, 8'h00, 8'h00);
      // A line number beyond the frame is a forced text line.
      send_item(OP_LINE_START, 8'd255, 8'h00);
      send_item(OP_SCREEN_BYTE, 8'h00, attr_byte(ATTR_MODE, 3'd7, 1'b1));
      send_item(OP_SCREEN_BYTE, 8'h00, 8'h61);
      send_item(OP_PATTERN_BYTE, 8'h00, 8'hC0);
      send_item(OP_FRAME_TICK, 8'hFF, 8'hFF);
   endtask

   // Flashing text with a period of one tick, so each tick flips the phase.
   task automatic test_flash_phase();
      write_flash_period(6'd1);
      send_item(OP_LINE_START, 8'd10, 8'h00);
      send_item(OP_SCREEN_BYTE, 8'h00, attr_byte(ATTR_TEXT, 3'd4, 1'b0));
      send_item(OP_SCREEN_BYTE, 8'h00, attr_byte(ATTR_BACK, 3'd2, 1'b0));
      send_item(OP_SCREEN_BYTE, 8'h00, 8'h48);
      send_item(OP_PATTERN_BYTE, 8'h00, 8'h3F);
      send_item(OP_FRAME_TICK, 8'h00, 8'h00);
      send_item(OP_SCREEN_BYTE, 8'h00, 8'hC8);
      send_item(OP_PATTERN_BYTE, 8'h00, 8'h15);
      send_item(OP_SCREEN_BYTE, 8'h00, attr_byte(ATTR_FORE, 3'd3, 1'b1));
      send_item(OP_FRAME_TICK, 8'h00, 8'h00);
      send_item(OP_SCREEN_BYTE, 8'h00, 8'h48);
      send_item(OP_PATTERN_BYTE, 8'h00, 8'h3C);
   endtask

   // Well-formed lines with random content, some run past the last cell.
   task automatic test_random_lines(input int target);
      int         start;
      int         pick;
      int         cells;
      logic [7:0] line;
      logic [7:0] value;
      start = effective_items;
      while (effective_items - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 5)) send_item(OP_FRAME_TICK, 8'($urandom), 8'($urandom));
         end else if (pick < 90) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               line = 8'd0;
            else if (pick < 3)
               line = 8'($urandom_range(GRAPHIC_LINES - 2, 255));
            else
               line = 8'($urandom);
            cells = ($urandom_range(0, 9) == 0) ? $urandom_range(38, 46) : $urandom_range(1, 10);
            send_item(OP_LINE_START, line, 8'($urandom));
            repeat (cells) begin
               if ($urandom_range(0, 4) == 0)
                  value = attr_byte(attr_group_type'($urandom_range(0, 3)), 3'($urandom),
                                    1'($urandom));
               else
                  value = 8'($urandom);
               if ($urandom_range(0, 29) == 0)
                  send_item(OP_FRAME_TICK, 8'($urandom), 8'($urandom));
               send_item(OP_SCREEN_BYTE, 8'($urandom), value);
               if (pat_awaited && $urandom_range(0, 19) != 0)
                  send_item(OP_PATTERN_BYTE, 8'($urandom), 8'($urandom));
            end
         end else begin
            send_item(opcode_type'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   // Unordered transactions of every kind.
   task automatic test_random_noise(input int target);
      int start;
      start = effective_items;
      while (effective_items - start < target)
         send_item(opcode_type'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
   endtask

   // Result side back-pressure.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   function automatic string describe_output(input rsp_payload_type o);
      return $sformatf("pix %0b/%02h fg %0d bg %0d cell %0d fetch %0b/%0b/%04h end %0b",
                       o.pixels_valid, o.pixel_bits, o.fore_colour, o.back_colour,
                       o.cell_index, o.fetch_valid, o.fetch_is_pattern, o.fetch_address,
                       o.line_end);
   endfunction

   // Compare each result transaction with the oldest prediction.
   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_video_out.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("unexpected result: %s", describe_output(rsp_payload));
         end else begin
            want = expected_video_out.pop_front();
            if (rsp_payload.pixels_valid !== want.pixels_valid ||
                rsp_payload.pixel_bits !== want.pixel_bits ||
                rsp_payload.fore_colour !== want.fore_colour ||
                rsp_payload.back_colour !== want.back_colour ||
                rsp_payload.cell_index !== want.cell_index ||
                rsp_payload.fetch_valid !== want.fetch_valid ||
                rsp_payload.fetch_is_pattern !== want.fetch_is_pattern ||
                rsp_payload.fetch_address !== want.fetch_address ||
                rsp_payload.line_end !== want.line_end) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT) begin
                  $display("mismatch expected: %s", describe_output(want));
                  $display("         actual:   %s", describe_output(rsp_payload));
               end
            end
         end
      end
   end

   // Watchdog on cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_serial_attribute_video_generator: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      flash_period_reg = FLASH_PERIOD_RESET;
      ras_line         = '0;
      ras_cell         = '0;
      ras_fore         = '0;
      ras_back         = '0;
      ras_text_attr    = '0;
      ras_mode         = '0;
      ras_base         = TEXT_SCREEN_BASE;
      ras_hires        = 1'b0;
      flash_ticks      = '0;
      flash_phase      = 1'b0;
      pend_invert      = 1'b0;
      pat_awaited      = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cells();
      wait_idle();
      test_flash_phase();
      wait_idle();

      // Longest period, with both sides running flat out.
      write_flash_period(6'd63);
      idle_on = 1'b0;
      test_random_lines(300);
      wait_idle();

      // A period of zero flips the phase once the counter wraps.
      write_flash_period(6'd0);
      idle_on = 1'b1;
      test_random_lines(300);
      wait_idle();

      write_flash_period(6'($urandom_range(1, 8)));
      test_random_lines(300);
      wait_idle();

      write_flash_period(FLASH_PERIOD_RESET);
      test_random_noise(200);
      wait_idle();

      write_flash_period(6'($urandom_range(2, 62)));
      test_random_lines(300);
      wait_idle();

      if (fault_count == 0 && expected_video_out.size() == 0)
         $display("tb_serial_attribute_video_generator: clean");
      else
         $display("tb_serial_attribute_video_generator: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/svg_pkg.sv
rtl/svg_front.sv
rtl/svg_queue.sv
rtl/svg_back.sv
rtl/serial_attribute_video_generator.sv
verif/tb_serial_attribute_video_generator.sv
